// ----- src/tdgc_pkg.sv -----
// Shared types and constants for the toroidal disk grid check block.
// Holds defaults, field widths, operation codes and register indexes.
// No dependencies.
package tdgc_pkg;

    localparam int GRID_CELLS_DEF     = 4096;
    localparam int COORD_BITS_DEF     = 20;
    localparam int FRAC_BITS_DEF      = 8;
    localparam int NEIGHBOR_REACH_DEF = 2;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 40;
    localparam int DOM_W       = 21;
    localparam int CELL_W      = 7;
    localparam int MIN_D2_W    = 40;
    localparam int RECIP_W     = 24;
    localparam int ADDR_PROD_W = 2 * CELL_W;

    localparam logic [DOM_W-1:0]    DOM_W_RST   = 21'd262144;
    localparam logic [DOM_W-1:0]    DOM_H_RST   = 21'd262144;
    localparam logic [CELL_W-1:0]   CELLS_RST   = 7'd64;
    localparam logic [MIN_D2_W-1:0] MIN_D2_RST  = 40'd65536;
    localparam logic [RECIP_W-1:0]  RECIP_RST   = 24'd16384;

    typedef enum logic [1:0] {
        OP_QUERY,
        OP_TEST_INSERT,
        OP_INSERT,
        OP_CLEAR
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOMAIN_WIDTH,
        CFG_DOMAIN_HEIGHT,
        CFG_CELLS_ACROSS,
        CFG_CELLS_DOWN,
        CFG_MIN_DIST_SQ,
        CFG_RECIP_ACROSS,
        CFG_RECIP_DOWN
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_NEG,
        SH_POS
    } t_shift;

    typedef struct packed {
        t_shift shx;
        t_shift shy;
        logic   center;
    } t_tag;

endpackage

// ----- src/toroidal_disk_grid_check.sv -----
// Toroidal background grid check for Poisson disk sampling: top level.
// Depends on tdgc_pkg and tdgc_ram.
//
// Each request maps its point to a grid cell (one multiply by the cell
// reciprocal per axis, clamped to the last cell) and then reads the
// (2*NEIGHBOR_REACH+1)^2 neighbor cells from the cell memory, one cell per
// cycle through its single read port, with the stored points of wrapped
// neighbors shifted by the domain size. A query, test-and-insert or insert
// request is paced by that read port and the distance pipeline behind it;
// an insert, or a test-and-insert that finds no close point, writes its
// cell once that pipeline has drained. A clear request sweeps the whole
// memory. After reset the same sweep runs over every cell and no request
// is taken until it ends; configuration writes are taken at any time. A
// finished result waits in an output register while the next request is
// accepted.
module toroidal_disk_grid_check #(
    parameter int GRID_CELLS     = tdgc_pkg::GRID_CELLS_DEF,
    parameter int COORD_BITS     = tdgc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS      = tdgc_pkg::FRAC_BITS_DEF,
    parameter int NEIGHBOR_REACH = tdgc_pkg::NEIGHBOR_REACH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [tdgc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tdgc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_op,
    input  logic [COORD_BITS-1:0]            i_point_x,
    input  logic [COORD_BITS-1:0]            i_point_y,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_is_free,
    output logic                             o_was_inserted
);

    localparam int AW        = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
    localparam int MEM_W     = 1 + 2 * COORD_BITS;
    localparam int SPAN      = 2 * NEIGHBOR_REACH + 1;
    localparam int CNT_W     = $clog2(SPAN);
    localparam int CW        = tdgc_pkg::CELL_W;
    localparam int NX_W      = CW + 3;
    localparam int MPW       = COORD_BITS + tdgc_pkg::RECIP_W;
    localparam int RSHIFT    = tdgc_pkg::RECIP_W + FRAC_BITS;
    localparam int DW        = ((COORD_BITS > tdgc_pkg::DOM_W) ? COORD_BITS
                                                                : tdgc_pkg::DOM_W) + 2;
    localparam int SQW       = 2 * DW;
    localparam int SUMW      = SQW + 1;
    localparam int PW        = tdgc_pkg::ADDR_PROD_W;
    localparam int RED_SPLIT = PW / 2;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_CELL,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE,
        ST_HOLD_A,
        ST_HOLD_B
    } t_state;

    typedef struct packed {
        logic [CW-1:0]    w;
        tdgc_pkg::t_shift sh;
    } t_wrap;

    // configuration
    logic [tdgc_pkg::DOM_W-1:0]    r_dom_w, r_dom_h;
    logic [CW-1:0]                 r_cells_x, r_cells_y;
    logic [tdgc_pkg::MIN_D2_W-1:0] r_min_d2;
    logic [tdgc_pkg::RECIP_W-1:0]  r_recip_x, r_recip_y;

    // control and request
    t_state                r_state;
    logic [AW-1:0]         r_sweep_addr;
    logic                  r_clr_op;
    tdgc_pkg::t_op         r_op;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic [MPW-1:0]        r_prod_x, r_prod_y;
    logic [CW-1:0]         r_cx, r_cy;
    logic [CNT_W-1:0]      r_dxi, r_dyi;
    logic                  r_blocked;
    logic                  r_ins;
    logic                  r_out_valid, r_is_free, r_was_ins;
    logic [AW-1:0]         r_home_addr;

    // neighbor pipeline
    logic                  r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld;
    logic [CW-1:0]         r_a_wx, r_a_wy;
    tdgc_pkg::t_tag        r_a_tag, r_b_tag, r_c_tag, r_d_tag;
    logic [PW-1:0]         r_b_prod, r_c_part;
    logic                  r_e_hit, r_f_hit;
    logic [DW-1:0]         r_e_ax, r_e_ay;
    logic [SQW-1:0]        r_f_sqx, r_f_sqy;

    logic [CW-1:0]         ca, cd, cx_next, cy_next;
    t_wrap                 wrap_x, wrap_y;
    logic [31:0]           red_hi, red_lo;
    logic [AW-1:0]         nbr_addr;
    logic                  pipe_empty, ins_wr, ram_we, in_acc, scan_last, close_hit;
    logic [SUMW-1:0]       dist_sum;
    logic [AW-1:0]         ram_waddr;
    logic [MEM_W-1:0]      ram_wdata, ram_rdata;
    logic [COORD_BITS-1:0] st_x, st_y;

    function automatic t_wrap wrap_cell(logic [CW-1:0] c, logic [CNT_W-1:0] d,
                                        logic [CW-1:0] n);
        logic [NX_W-1:0] w;
        t_wrap           r;
        w = NX_W'(c) + NX_W'(d) - NX_W'(NEIGHBOR_REACH);
        if (w[NX_W-1]) begin
            r.sh = tdgc_pkg::SH_NEG;
        end else if (w >= NX_W'(n)) begin
            r.sh = tdgc_pkg::SH_POS;
        end else begin
            r.sh = tdgc_pkg::SH_NONE;
        end
        for (int i = 0; i < NEIGHBOR_REACH; i++) begin
            if (w[NX_W-1]) begin
                w = w + NX_W'(n);
            end else if (w >= NX_W'(n)) begin
                w = w - NX_W'(n);
            end
        end
        r.w = w[CW-1:0];
        return r;
    endfunction

    function automatic logic [DW-1:0] shifted_abs(logic [COORD_BITS-1:0] p,
                                                  logic [COORD_BITS-1:0] s,
                                                  logic [tdgc_pkg::DOM_W-1:0] dom,
                                                  tdgc_pkg::t_shift sh);
        logic [DW-1:0] d;
        d = DW'(p) - DW'(s);
        unique case (sh)
            tdgc_pkg::SH_NEG: d = d + DW'(dom);
            tdgc_pkg::SH_POS: d = d - DW'(dom);
            default:          d = d;
        endcase
        return d[DW-1] ? (~d + DW'(1)) : d;
    endfunction

    function automatic logic [CW-1:0] clamp_cell(logic [MPW-1:0] prod, logic [CW-1:0] n);
        logic [MPW-1:0] idx;
        idx = prod >> RSHIFT;
        return (idx >= MPW'(n)) ? (n - CW'(1)) : idx[CW-1:0];
    endfunction

    assign ca = (r_cells_x == '0) ? CW'(1) : r_cells_x;
    assign cd = (r_cells_y == '0) ? CW'(1) : r_cells_y;

    assign cx_next = clamp_cell(r_prod_x, ca);
    assign cy_next = clamp_cell(r_prod_y, cd);
    assign wrap_x  = wrap_cell(r_cx, r_dxi, ca);
    assign wrap_y  = wrap_cell(r_cy, r_dyi, cd);

    assign scan_last = (r_dxi == CNT_W'(SPAN - 1)) && (r_dyi == CNT_W'(SPAN - 1));

    // cell address modulo memory depth, split over two stages
    always_comb begin
        red_hi = 32'(r_b_prod);
        for (int k = PW - 1; k >= RED_SPLIT; k--) begin
            if (red_hi >= (32'(GRID_CELLS) << k)) begin
                red_hi = red_hi - (32'(GRID_CELLS) << k);
            end
        end
    end

    always_comb begin
        red_lo = 32'(r_c_part);
        for (int k = RED_SPLIT - 1; k >= 0; k--) begin
            if (red_lo >= (32'(GRID_CELLS) << k)) begin
                red_lo = red_lo - (32'(GRID_CELLS) << k);
            end
        end
    end

    assign nbr_addr = red_lo[AW-1:0];

    assign st_x = ram_rdata[2*COORD_BITS-1:COORD_BITS];
    assign st_y = ram_rdata[COORD_BITS-1:0];

    assign dist_sum  = SUMW'(r_f_sqx) + SUMW'(r_f_sqy);
    assign close_hit = r_f_vld && r_f_hit && (dist_sum < SUMW'(r_min_d2));

    assign pipe_empty = !(r_a_vld || r_b_vld || r_c_vld || r_d_vld || r_e_vld || r_f_vld);
    assign ins_wr     = (r_state == ST_DRAIN) && pipe_empty
                        && ((r_op == tdgc_pkg::OP_INSERT)
                            || ((r_op == tdgc_pkg::OP_TEST_INSERT) && !r_blocked));
    assign ram_we     = (r_state == ST_SWEEP) || ins_wr;
    assign ram_waddr  = (r_state == ST_SWEEP) ? r_sweep_addr : r_home_addr;
    assign ram_wdata  = (r_state == ST_SWEEP) ? '0 : {1'b1, r_px, r_py};

    assign o_in_stall     = (r_state != ST_IDLE);
    assign in_acc         = i_in_valid && !o_in_stall;
    assign o_out_valid    = r_out_valid;
    assign o_is_free      = r_is_free;
    assign o_was_inserted = r_was_ins;

    tdgc_ram #(
        .WIDTH (MEM_W),
        .DEPTH (GRID_CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (nbr_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dom_w   <= tdgc_pkg::DOM_W_RST;
            r_dom_h   <= tdgc_pkg::DOM_H_RST;
            r_cells_x <= tdgc_pkg::CELLS_RST;
            r_cells_y <= tdgc_pkg::CELLS_RST;
            r_min_d2  <= tdgc_pkg::MIN_D2_RST;
            r_recip_x <= tdgc_pkg::RECIP_RST;
            r_recip_y <= tdgc_pkg::RECIP_RST;
        end else if (i_cfg_wr_en) begin
            unique case (tdgc_pkg::t_cfg_idx'(i_cfg_index))
                tdgc_pkg::CFG_DOMAIN_WIDTH:  r_dom_w   <= i_cfg_wdata[tdgc_pkg::DOM_W-1:0];
                tdgc_pkg::CFG_DOMAIN_HEIGHT: r_dom_h   <= i_cfg_wdata[tdgc_pkg::DOM_W-1:0];
                tdgc_pkg::CFG_CELLS_ACROSS:  r_cells_x <= i_cfg_wdata[CW-1:0];
                tdgc_pkg::CFG_CELLS_DOWN:    r_cells_y <= i_cfg_wdata[CW-1:0];
                tdgc_pkg::CFG_MIN_DIST_SQ:   r_min_d2  <= i_cfg_wdata[tdgc_pkg::MIN_D2_W-1:0];
                tdgc_pkg::CFG_RECIP_ACROSS:  r_recip_x <= i_cfg_wdata[tdgc_pkg::RECIP_W-1:0];
                tdgc_pkg::CFG_RECIP_DOWN:    r_recip_y <= i_cfg_wdata[tdgc_pkg::RECIP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_addr <= '0;
            r_clr_op     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_blocked    <= 1'b0;
            r_ins        <= 1'b0;
            r_op         <= tdgc_pkg::OP_QUERY;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_SWEEP: begin
                    r_sweep_addr <= (r_sweep_addr == AW'(GRID_CELLS - 1))
                                    ? '0 : r_sweep_addr + AW'(1);
                    if (r_sweep_addr == AW'(GRID_CELLS - 1)) begin
                        r_state <= r_clr_op ? ST_DONE : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_op      <= tdgc_pkg::t_op'(i_op);
                        r_px      <= i_point_x;
                        r_py      <= i_point_y;
                        r_prod_x  <= MPW'(i_point_x) * MPW'(r_recip_x);
                        r_prod_y  <= MPW'(i_point_y) * MPW'(r_recip_y);
                        r_blocked <= 1'b0;
                        r_ins     <= 1'b0;
                        r_clr_op  <= (tdgc_pkg::t_op'(i_op) == tdgc_pkg::OP_CLEAR);
                        r_state   <= (tdgc_pkg::t_op'(i_op) == tdgc_pkg::OP_CLEAR)
                                     ? ST_SWEEP : ST_CELL;
                    end
                end
                ST_CELL: begin
                    r_cx    <= cx_next;
                    r_cy    <= cy_next;
                    r_dxi   <= '0;
                    r_dyi   <= '0;
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (r_dxi == CNT_W'(SPAN - 1)) begin
                        r_dxi <= '0;
                        r_dyi <= r_dyi + CNT_W'(1);
                    end else begin
                        r_dxi <= r_dxi + CNT_W'(1);
                    end
                    if (scan_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (pipe_empty) begin
                        r_ins   <= ins_wr;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_is_free   <= !r_blocked;
                        r_was_ins   <= r_ins;
                        r_clr_op    <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_HOLD_A: r_state <= ST_IDLE;
                ST_HOLD_B: r_state <= ST_IDLE;
            endcase
            if (close_hit) begin
                r_blocked <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else begin
            r_a_vld <= (r_state == ST_SCAN);
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
        end

        // wrapped column and row, shift direction
        r_a_wx         <= wrap_x.w;
        r_a_wy         <= wrap_y.w;
        r_a_tag.shx    <= wrap_x.sh;
        r_a_tag.shy    <= wrap_y.sh;
        r_a_tag.center <= (r_dxi == CNT_W'(NEIGHBOR_REACH))
                          && (r_dyi == CNT_W'(NEIGHBOR_REACH));

        // linear cell index and its reduction
        r_b_prod <= PW'(r_a_wy) * PW'(ca) + PW'(r_a_wx);
        r_b_tag  <= r_a_tag;
        r_c_part <= red_hi[PW-1:0];
        r_c_tag  <= r_b_tag;

        // memory read issued from stage c, data back with stage d
        r_d_tag <= r_c_tag;
        if (r_c_vld && r_c_tag.center) begin
            r_home_addr <= nbr_addr;
        end

        r_e_hit <= ram_rdata[MEM_W-1];
        r_e_ax  <= shifted_abs(r_px, st_x, r_dom_w, r_d_tag.shx);
        r_e_ay  <= shifted_abs(r_py, st_y, r_dom_h, r_d_tag.shy);

        r_f_hit <= r_e_hit;
        r_f_sqx <= SQW'(r_e_ax) * SQW'(r_e_ax);
        r_f_sqy <= SQW'(r_e_ay) * SQW'(r_e_ay);
    end

`ifndef ASSERT_OFF
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> pipe_empty)
        else $error("cell write while neighbor reads in flight");

    a_scan_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld |-> $past(r_state == ST_SCAN))
        else $error("neighbor issued outside scan");

    a_insert_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ins |-> (r_op == tdgc_pkg::OP_INSERT || r_op == tdgc_pkg::OP_TEST_INSERT))
        else $error("insert flagged for a request that cannot insert");

    a_accept_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && tdgc_pkg::t_op'(i_op) != tdgc_pkg::OP_CLEAR) |=> (r_state == ST_CELL))
        else $error("accepted request did not start cell lookup");
`endif

endmodule

// ----- src/tdgc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the cell store of the grid check block. No dependencies.
module tdgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Testbench for toroidal_disk_grid_check: directed and random point requests
// checked against a built-in grid predictor. Depends on tdgc_pkg and the block.
module tb;

    localparam int XW         = tdgc_pkg::COORD_BITS_DEF;
    localparam int CELLS      = tdgc_pkg::GRID_CELLS_DEF;
    localparam int REACH      = tdgc_pkg::NEIGHBOR_REACH_DEF;
    localparam int SCALE_SH   = tdgc_pkg::RECIP_W + tdgc_pkg::FRAC_BITS_DEF;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        tdgc_pkg::t_op  op;
        logic [XW-1:0]  x;
        logic [XW-1:0]  y;
    } t_point_req;

    typedef struct packed {
        logic free;
        logic inserted;
    } t_verdict;

    typedef enum {NEAR_POINT, NEAR_RIM, IN_DOMAIN, ANYWHERE} t_spot;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_wr_en = 1'b0;
    logic [tdgc_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [tdgc_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    logic [1:0]                      i_op = '0;
    logic [XW-1:0]                   i_point_x = '0;
    logic [XW-1:0]                   i_point_y = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic                            o_is_free;
    logic                            o_was_inserted;

    // predictor copy of the registers and the cell store
    logic [tdgc_pkg::DOM_W-1:0]    dom_w = tdgc_pkg::DOM_W_RST;
    logic [tdgc_pkg::DOM_W-1:0]    dom_h = tdgc_pkg::DOM_H_RST;
    logic [tdgc_pkg::CELL_W-1:0]   cols = tdgc_pkg::CELLS_RST;
    logic [tdgc_pkg::CELL_W-1:0]   rows = tdgc_pkg::CELLS_RST;
    logic [tdgc_pkg::MIN_D2_W-1:0] min_d2 = tdgc_pkg::MIN_D2_RST;
    logic [tdgc_pkg::RECIP_W-1:0]  rcp_x = tdgc_pkg::RECIP_RST;
    logic [tdgc_pkg::RECIP_W-1:0]  rcp_y = tdgc_pkg::RECIP_RST;
    bit                            cell_used [CELLS];
    longint                        cell_px [CELLS];
    longint                        cell_py [CELLS];

    t_point_req point_requests[$];
    t_verdict   pending_verdicts[$];
    longint     recent_x[$] = '{0};
    longint     recent_y[$] = '{0};

    longint gen_w, gen_h, gen_reach;
    bit     calm = 1'b0;
    int     gap_left = 0;
    int     stall_left = 0;
    int     idle_cycles = 0;
    int     faults = 0;
    int     settings = 1;
    int     n_req = 0, n_free = 0, n_blocked = 0, n_inserted = 0, n_clears = 0;

    toroidal_disk_grid_check DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_is_free      (o_is_free),
        .o_was_inserted (o_was_inserted)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint cell_index(longint unsigned coord,
                                          logic [tdgc_pkg::RECIP_W-1:0] rcp,
                                          longint count);
        longint unsigned idx;
        idx = (coord * rcp) >> SCALE_SH;
        if (idx >= longint'(count)) idx = count - 1;
        return longint'(idx);
    endfunction

    function automatic longint unsigned square(longint d);
        longint a;
        a = (d < 0) ? -d : d;
        return a * a;
    endfunction

    function automatic t_verdict judge_point(tdgc_pkg::t_op op, logic [XW-1:0] bx,
                                             logic [XW-1:0] by);
        t_verdict v;
        longint px, py, ca, cd, cx, cy, nx, ny, shx, shy, wx, wy;
        longint unsigned dist2;
        int addr, dx, dy;
        px = bx;
        py = by;
        ca = (cols == 0) ? 1 : cols;
        cd = (rows == 0) ? 1 : rows;
        v.free = 1'b1;
        v.inserted = 1'b0;
        if (op == tdgc_pkg::OP_CLEAR) begin
            foreach (cell_used[i]) cell_used[i] = 1'b0;
            return v;
        end
        cx = cell_index(px, rcp_x, ca);
        cy = cell_index(py, rcp_y, cd);
        for (dy = -REACH; dy <= REACH; dy++) begin
            for (dx = -REACH; dx <= REACH; dx++) begin
                nx = cx + dx;
                ny = cy + dy;
                shx = (nx < 0) ? -longint'(dom_w) : (nx >= ca) ? longint'(dom_w) : 0;
                shy = (ny < 0) ? -longint'(dom_h) : (ny >= cd) ? longint'(dom_h) : 0;
                wx = ((nx % ca) + ca) % ca;
                wy = ((ny % cd) + cd) % cd;
                addr = int'((wy * ca + wx) % CELLS);
                if (cell_used[addr]) begin
                    dist2 = square(px - cell_px[addr] - shx) + square(py - cell_py[addr] - shy);
                    if (dist2 < min_d2) v.free = 1'b0;
                end
            end
        end
        if (op == tdgc_pkg::OP_INSERT || (op == tdgc_pkg::OP_TEST_INSERT && v.free)) begin
            addr = int'((cy * ca + cx) % CELLS);
            cell_used[addr] = 1'b1;
            cell_px[addr] = px;
            cell_py[addr] = py;
            v.inserted = 1'b1;
        end
        return v;
    endfunction

    function automatic int pick_idle();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // request driver, predicts each accepted request
    always @(posedge i_clk) begin
        t_point_req req;
        t_verdict   v;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                v = judge_point(tdgc_pkg::t_op'(i_op), i_point_x, i_point_y);
                pending_verdicts = {pending_verdicts, v};
                n_req++;
                if (tdgc_pkg::t_op'(i_op) == tdgc_pkg::OP_CLEAR) n_clears++;
                else if (v.free) n_free++;
                else n_blocked++;
                if (v.inserted) n_inserted++;
                gap_left = pick_idle();
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left == 0 && point_requests.size() != 0) begin
                    req = point_requests.pop_front();
                    i_in_valid <= 1'b1;
                    i_op <= req.op;
                    i_point_x <= req.x;
                    i_point_y <= req.y;
                end else begin
                    i_in_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end
            end
        end
    end

    // result monitor and output stall
    always @(posedge i_clk) begin
        t_verdict want;
        int n;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_verdicts.size() == 0) begin
                    $display("%0t unexpected result: is_free %0b was_inserted %0b",
                             $time, o_is_free, o_was_inserted);
                    faults++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (o_is_free !== want.free) begin
                        $display("%0t is_free mismatch: expected %0b actual %0b",
                                 $time, want.free, o_is_free);
                        faults++;
                    end
                    if (o_was_inserted !== want.inserted) begin
                        $display("%0t was_inserted mismatch: expected %0b actual %0b",
                                 $time, want.inserted, o_was_inserted);
                        faults++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                n = pick_idle();
                if (n > 0 && $urandom_range(0, 3) == 0) begin
                    stall_left = n - 1;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t watchdog: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(tdgc_pkg::t_cfg_idx idx, longint val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val[tdgc_pkg::CFG_DATA_W-1:0];
        unique case (idx)
            tdgc_pkg::CFG_DOMAIN_WIDTH:  dom_w = val[tdgc_pkg::DOM_W-1:0];
            tdgc_pkg::CFG_DOMAIN_HEIGHT: dom_h = val[tdgc_pkg::DOM_W-1:0];
            tdgc_pkg::CFG_CELLS_ACROSS:  cols = val[tdgc_pkg::CELL_W-1:0];
            tdgc_pkg::CFG_CELLS_DOWN:    rows = val[tdgc_pkg::CELL_W-1:0];
            tdgc_pkg::CFG_MIN_DIST_SQ:   min_d2 = val[tdgc_pkg::MIN_D2_W-1:0];
            tdgc_pkg::CFG_RECIP_ACROSS:  rcp_x = val[tdgc_pkg::RECIP_W-1:0];
            tdgc_pkg::CFG_RECIP_DOWN:    rcp_y = val[tdgc_pkg::RECIP_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_grid(longint dw, longint dh, longint ca, longint cd, longint d2,
                            longint rx, longint ry);
        write_reg(tdgc_pkg::CFG_DOMAIN_WIDTH, dw);
        write_reg(tdgc_pkg::CFG_DOMAIN_HEIGHT, dh);
        write_reg(tdgc_pkg::CFG_CELLS_ACROSS, ca);
        write_reg(tdgc_pkg::CFG_CELLS_DOWN, cd);
        write_reg(tdgc_pkg::CFG_MIN_DIST_SQ, d2);
        write_reg(tdgc_pkg::CFG_RECIP_ACROSS, rx);
        write_reg(tdgc_pkg::CFG_RECIP_DOWN, ry);
        gen_w = dom_w;
        gen_h = dom_h;
        gen_reach = 4096;
        settings++;
    endtask

    // consistent geometry: reciprocal of the cell size from domain and count
    task automatic fit_grid(longint dw, longint dh, longint ca, longint cd, longint rad);
        longint rx, ry;
        rx = (longint'((ca == 0) ? 1 : ca) << 32) / dw;
        ry = (longint'((cd == 0) ? 1 : cd) << 32) / dh;
        if (rx > 24'hFFFFFF) rx = 24'hFFFFFF;
        if (ry > 24'hFFFFFF) ry = 24'hFFFFFF;
        set_grid(dw, dh, ca, cd, rad * rad, rx, ry);
        gen_reach = rad;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (point_requests.size() != 0 || i_in_valid || pending_verdicts.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic void post(tdgc_pkg::t_op op, logic [XW-1:0] x, logic [XW-1:0] y);
        t_point_req r;
        r.op = op;
        r.x = x;
        r.y = y;
        point_requests = {point_requests, r};
    endfunction

    function automatic longint clip_span(longint d);
        if (d <= 0) return 1;
        if (d > (1 << XW)) return 1 << XW;
        return d;
    endfunction

    function automatic logic [XW-1:0] place(t_spot spot, longint base, longint lim,
                                            longint reach);
        longint v;
        unique case (spot)
            NEAR_POINT: v = base + longint'($urandom_range(0, 4 * reach)) - 2 * reach;
            NEAR_RIM: begin
                v = longint'($urandom_range(0, reach)) % lim;
                if ($urandom_range(0, 1)) v = lim - 1 - v;
            end
            IN_DOMAIN: v = longint'($urandom_range(0, lim - 1));
            default: return XW'($urandom_range(0, (1 << XW) - 1));
        endcase
        v = ((v % lim) + lim) % lim;
        return v[XW-1:0];
    endfunction

    task automatic queue_random(int count);
        t_point_req r;
        t_spot spot;
        int k, h, roll;
        longint lim_x, lim_y;
        lim_x = clip_span(gen_w);
        lim_y = clip_span(gen_h);
        @(negedge i_clk);
        for (k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 79) == 0) r.op = tdgc_pkg::OP_CLEAR;
            else if (roll < 50) r.op = tdgc_pkg::OP_TEST_INSERT;
            else if (roll < 75) r.op = tdgc_pkg::OP_QUERY;
            else r.op = tdgc_pkg::OP_INSERT;
            roll = $urandom_range(0, 99);
            if (roll < 35) spot = NEAR_POINT;
            else if (roll < 50) spot = NEAR_RIM;
            else if (roll < 90) spot = IN_DOMAIN;
            else spot = ANYWHERE;
            h = $urandom_range(0, recent_x.size() - 1);
            r.x = place(spot, recent_x[h], lim_x, gen_reach);
            r.y = place(spot, recent_y[h], lim_y, gen_reach);
            point_requests = {point_requests, r};
            recent_x = {recent_x, longint'(r.x)};
            recent_y = {recent_y, longint'(r.y)};
            if (recent_x.size() > 24) begin
                void'(recent_x.pop_front());
                void'(recent_y.pop_front());
            end
        end
    endtask

    initial begin
        longint ca, cd, dw, dh, cmin;
        int p;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: hit, miss, forced insert, clear, far corner
        post(tdgc_pkg::OP_QUERY, 0, 0);
        post(tdgc_pkg::OP_TEST_INSERT, 0, 0);
        post(tdgc_pkg::OP_TEST_INSERT, 100, 100);
        post(tdgc_pkg::OP_INSERT, 100, 100);
        post(tdgc_pkg::OP_QUERY, '1, '1);
        post(tdgc_pkg::OP_TEST_INSERT, '1, 0);
        post(tdgc_pkg::OP_CLEAR, 0, 0);
        post(tdgc_pkg::OP_QUERY, 100, 100);
        post(tdgc_pkg::OP_TEST_INSERT, 262143, 262143);
        wait_idle();

        // 3x2 grid, neighbors wrap across both edges
        fit_grid(768, 512, 3, 2, 128);
        @(negedge i_clk);
        post(tdgc_pkg::OP_TEST_INSERT, 5, 5);
        post(tdgc_pkg::OP_TEST_INSERT, 763, 5);
        post(tdgc_pkg::OP_TEST_INSERT, 5, 508);
        post(tdgc_pkg::OP_QUERY, 763, 508);
        wait_idle();

        // zero cell counts act as a single cell
        set_grid(768, 512, 0, 0, 16384, 24'hFFFFFF, 24'hFFFFFF);
        @(negedge i_clk);
        post(tdgc_pkg::OP_TEST_INSERT, 10, 10);
        post(tdgc_pkg::OP_TEST_INSERT, 20, 20);
        post(tdgc_pkg::OP_QUERY, 700, 500);
        wait_idle();

        // zero distance never blocks
        set_grid(1, 1, 64, 64, 0, 0, 0);
        @(negedge i_clk);
        post(tdgc_pkg::OP_INSERT, 50, 50);
        post(tdgc_pkg::OP_TEST_INSERT, 50, 50);
        wait_idle();

        // 100x100 grid aliases past the store, widest distance
        set_grid(21'h100000, 21'h100000, 100, 100, 40'hFFFFFFFFFF, 409600, 409600);
        @(negedge i_clk);
        post(tdgc_pkg::OP_INSERT, '1, '1);
        post(tdgc_pkg::OP_QUERY, 78643, 193986);
        wait_idle();

        for (p = 0; p < 8; p++) begin
            ca = $urandom_range(1, 64);
            cd = $urandom_range(1, 64);
            dw = $urandom_range(256, 21'h100000);
            dh = $urandom_range(256, 21'h100000);
            case (p)
                1: begin
                    ca = $urandom_range(1, 4);
                    cd = $urandom_range(1, 4);
                    dw = $urandom_range(512, 8192);
                    dh = $urandom_range(512, 8192);
                end
                4: begin
                    ca = $urandom_range(65, 127);
                    cd = $urandom_range(65, 127);
                    dw = 21'h100000;
                    dh = 21'h100000;
                end
                5: ca = 0;
                default: ;
            endcase
            cmin = (dw / ((ca == 0) ? 1 : ca) < dh / cd) ? dw / ((ca == 0) ? 1 : ca) : dh / cd;
            if (cmin < 1) cmin = 1;
            if (p == 0) begin
                fit_grid(262144, 262144, 64, 64, 2048);
            end else if (p == 6) begin
                set_grid($urandom_range(0, 21'h1FFFFF), $urandom_range(0, 21'h1FFFFF),
                         $urandom_range(0, 127), $urandom_range(0, 127),
                         (longint'($urandom_range(0, 255)) << 32) | longint'($urandom),
                         $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
            end else if (p == 7) begin
                fit_grid(dw, dh, ca, cd, $urandom_range(cmin, 3 * cmin));
            end else begin
                fit_grid(dw, dh, ca, cd, $urandom_range((cmin + 1) / 2, cmin));
            end
            calm = (p == 2);
            if (p == 3) begin
                // sender holds off after the first batch until each of its requests has its result
                queue_random(35);
                wait_idle();
                queue_random(34);
            end else begin
                queue_random(69);
            end
            wait_idle();
        end
        calm = 1'b0;

        repeat (60) @(posedge i_clk);
        if (pending_verdicts.size() != 0) begin
            $display("%0t %0d results never arrived", $time, pending_verdicts.size());
            faults++;
        end
        $display("covered %0d requests under %0d register settings", n_req, settings);
        $display("%0d free, %0d blocked, %0d inserted, %0d clears",
                 n_free, n_blocked, n_inserted, n_clears);
        if (faults == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- toroidal_disk_grid_check.f -----
src/tdgc_pkg.sv
src/tdgc_ram.sv
src/toroidal_disk_grid_check.sv
dv/tb.sv
